/* sv/subtractive_random_generator_macros.svh */
// Assertion macros shared by the generator's RTL.
`ifndef SUBTRACTIVE_RANDOM_GENERATOR_MACROS_SVH
`define SUBTRACTIVE_RANDOM_GENERATOR_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define SRG_ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("srg invariant violated");

// The consequent holds in the same cycle as the antecedent.
`define SRG_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("srg implication violated");

// The consequent holds in the cycle after the antecedent.
`define SRG_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("srg sequence violated");

`endif

/* sv/srg_pkg.sv */
package srg_pkg;

  localparam int WordW     = 31;
  localparam int SeedW     = 25;
  localparam int MixOffset = 31;
  localparam int MixPasses = 4;

  typedef logic [WordW-1:0] srg_word_t;

  typedef struct packed {
    logic      start;
    srg_word_t value;
  } srg_red_req_t;

  typedef enum logic {
    OP_SEED = 1'b0,
    OP_NEXT = 1'b1
  } srg_op_e;

  typedef enum logic {
    REG_MODULUS     = 1'b0,
    REG_SEED_OFFSET = 1'b1
  } srg_reg_e;

  localparam srg_word_t ModulusReset    = 31'd1000000000;
  localparam srg_word_t SeedOffsetReset = 31'd161803398;

endpackage

/* sv/srg_ram.sv */
module srg_ram #(
  parameter int Width = 32,
  parameter int Depth = 64,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_a_i,
  input  logic [AddrW-1:0] raddr_b_i,
  output logic [Width-1:0] rdata_a_o,
  output logic [Width-1:0] rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_a_q;
  logic [Width-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

/* sv/srg_modred.sv */
module srg_modred
  import srg_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  srg_red_req_t req_i,
  input  srg_word_t    modulus_i,
  output logic         busy_o,
  output srg_word_t    result_o
);

  localparam int CntW = $clog2(WordW);

  logic            busy_q, busy_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  srg_word_t       rem_q, rem_d;
  srg_word_t       dvd_q, dvd_d;
  logic [WordW:0]  trial;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    trial  = {rem_q, dvd_q[WordW-1]};
    if (req_i.start) begin
      if (req_i.value < modulus_i) begin
        rem_d  = req_i.value;
        busy_d = 1'b0;
      end else begin
        rem_d  = '0;
        dvd_d  = req_i.value;
        cnt_d  = CntW'(WordW - 1);
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      if (trial >= {1'b0, modulus_i}) begin
        rem_d = trial[WordW-1:0] - modulus_i;
      end else begin
        rem_d = trial[WordW-1:0];
      end
      dvd_d = dvd_q << 1;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
  end

  assign busy_o   = busy_q;
  assign result_o = rem_q;

endmodule

/* sv/subtractive_random_generator.sv */
// Next item: both table entries are registered, then fed to both reducers; m_axis_tvalid rises
// once both are done and the output is free, and only then is a new item taken. A table entry at
// or above the modulus adds bit-serial reduction. Seed item: the start value is reduced if needed,
// then one scatter write per cycle, then four mixing passes at one entry per cycle through the
// dual-read table RAM; it gives no result. Reset clears the position, the handshakes and the
// reducers and loads the published register values; the table is undefined until first seeded.
`include "subtractive_random_generator_macros.svh"

module subtractive_random_generator
  import srg_pkg::*;
#(
  parameter int TABLE_SIZE = 55,
  parameter int STRIDE     = 21
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // [24:0] seed, [31:25] zero
  input  logic        s_axis_tuser,  // [0] op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // [30:0] value, [31] zero
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AddrW = $clog2(TABLE_SIZE);
  localparam int StepW = $clog2(MixPasses * TABLE_SIZE + 1);
  localparam int ScatW = $clog2(TABLE_SIZE + 1);

  typedef logic [AddrW-1:0] addr_t;

  localparam addr_t             StrideA   = addr_t'(STRIDE % TABLE_SIZE);
  localparam addr_t             MixStartA = addr_t'(MixOffset % TABLE_SIZE);
  localparam addr_t             LastA     = addr_t'(TABLE_SIZE - 1);
  localparam logic [AddrW:0]    SizeW     = (AddrW + 1)'(TABLE_SIZE);
  localparam logic [StepW-1:0]  MixSteps  = StepW'(MixPasses * TABLE_SIZE);
  localparam logic [ScatW-1:0]  ScatLimit = ScatW'(TABLE_SIZE);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NX_LOAD,
    ST_NX_RED,
    ST_SD_RED,
    ST_SCAT,
    ST_MIX
  } state_e;

  function automatic addr_t wrap_inc(addr_t x);
    wrap_inc = (x == LastA) ? '0 : x + 1'b1;
  endfunction

  function automatic addr_t wrap_add(addr_t x, addr_t y);
    logic [AddrW:0] sum;
    sum = {1'b0, x} + {1'b0, y};
    if (sum >= SizeW) begin
      sum = sum - SizeW;
    end
    wrap_add = sum[AddrW-1:0];
  endfunction

  function automatic srg_word_t sub_mod(srg_word_t x, srg_word_t y, srg_word_t m);
    sub_mod = (x >= y) ? x - y : x + (m - y);
  endfunction

  state_e           state_q, state_d;
  addr_t            pos_q, pos_d;
  logic             m_valid_q, m_valid_d;
  srg_word_t        m_data_q, m_data_d;
  srg_word_t        modulus_q, modulus_d;
  srg_word_t        seed_offset_q, seed_offset_d;
  srg_word_t        mj_q, mj_d;
  srg_word_t        mk_q, mk_d;
  addr_t            idx_i_q, idx_i_d;
  addr_t            idx_k_q, idx_k_d;
  logic [ScatW-1:0] scat_n_q, scat_n_d;
  logic [StepW-1:0] step_q, step_d;
  logic             eval_q, eval_d;
  addr_t            wa_q, wa_d;
  logic             fwd_a_q, fwd_a_d;
  logic             fwd_b_q, fwd_b_d;
  srg_word_t        fwd_data_q, fwd_data_d;

  logic             ram_we;
  addr_t            ram_waddr;
  srg_word_t        ram_wdata;
  logic             ram_re;
  addr_t            raddr_a;
  addr_t            raddr_b;
  srg_word_t        rdata_a;
  srg_word_t        rdata_b;

  srg_red_req_t     req_a;
  srg_red_req_t     req_b;
  logic             busy_a;
  logic             busy_b;
  srg_word_t        res_a;
  srg_word_t        res_b;

  srg_word_t        m_eff;
  srg_word_t        op_a;
  srg_word_t        op_b;
  logic             s_fire;
  logic             out_free;
  logic             cfg_write;
  logic [SeedW-1:0] seed_raw;
  logic [SeedW-1:0] seed_mag;
  logic [WordW:0]   diff;
  logic [WordW:0]   diff_neg;
  srg_word_t        start_val;

  srg_ram #(
    .Width (WordW),
    .Depth (TABLE_SIZE)
  ) u_table (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .re_i      (ram_re),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  srg_modred u_red_a (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_a),
    .modulus_i (m_eff),
    .busy_o    (busy_a),
    .result_o  (res_a)
  );

  srg_modred u_red_b (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_b),
    .modulus_i (m_eff),
    .busy_o    (busy_b),
    .result_o  (res_b)
  );

  assign m_eff    = (modulus_q < srg_word_t'(2)) ? srg_word_t'(2) : modulus_q;
  assign op_a     = fwd_a_q ? fwd_data_q : rdata_a;
  assign op_b     = fwd_b_q ? fwd_data_q : rdata_b;
  assign s_fire   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_valid_q || m_axis_tready;

  assign seed_raw  = s_axis_tdata[SeedW-1:0];
  assign seed_mag  = seed_raw[SeedW-1] ? -seed_raw : seed_raw;
  assign diff      = {1'b0, seed_offset_q} - {{(WordW + 1 - SeedW){1'b0}}, seed_mag};
  assign diff_neg  = -diff;
  assign start_val = diff[WordW] ? diff_neg[WordW-1:0] : diff[WordW-1:0];

  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    modulus_d     = modulus_q;
    seed_offset_d = seed_offset_q;
    if (cfg_write) begin
      case (srg_reg_e'(paddr[2]))
        REG_MODULUS:     modulus_d     = pwdata[WordW-1:0];
        REG_SEED_OFFSET: seed_offset_d = pwdata[WordW-1:0];
        default:         modulus_d     = modulus_q;
      endcase
    end
  end

  always_comb begin
    case (srg_reg_e'(paddr[2]))
      REG_MODULUS:     prdata = {1'b0, modulus_q};
      REG_SEED_OFFSET: prdata = {1'b0, seed_offset_q};
      default:         prdata = '0;
    endcase
  end

  always_comb begin
    state_d    = state_q;
    pos_d      = pos_q;
    m_valid_d  = m_valid_q && !m_axis_tready;
    m_data_d   = m_data_q;
    mj_d       = mj_q;
    mk_d       = mk_q;
    idx_i_d    = idx_i_q;
    idx_k_d    = idx_k_q;
    scat_n_d   = scat_n_q;
    step_d     = step_q;
    eval_d     = 1'b0;
    wa_d       = wa_q;
    ram_we     = 1'b0;
    ram_waddr  = wa_q;
    ram_wdata  = '0;
    ram_re     = 1'b0;
    raddr_a    = pos_q;
    raddr_b    = pos_q;
    req_a      = '0;
    req_b      = '0;

    case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          if (srg_op_e'(s_axis_tuser) == OP_NEXT) begin
            pos_d   = wrap_inc(pos_q);
            ram_re  = 1'b1;
            raddr_a = pos_d;
            raddr_b = wrap_add(pos_d, StrideA);
            state_d = ST_NX_LOAD;
          end else begin
            req_a.start = 1'b1;
            req_a.value = start_val;
            state_d     = ST_SD_RED;
          end
        end
      end
      ST_NX_LOAD: begin
        req_a.start = 1'b1;
        req_a.value = op_a;
        req_b.start = 1'b1;
        req_b.value = op_b;
        state_d     = ST_NX_RED;
      end
      ST_NX_RED: begin
        if (!busy_a && !busy_b && out_free) begin
          ram_we    = 1'b1;
          ram_waddr = pos_q;
          ram_wdata = sub_mod(res_a, res_b, m_eff);
          m_valid_d = 1'b1;
          m_data_d  = ram_wdata;
          state_d   = ST_IDLE;
        end
      end
      ST_SD_RED: begin
        if (!busy_a) begin
          ram_we    = 1'b1;
          ram_waddr = '0;
          ram_wdata = res_a;
          mj_d      = res_a;
          mk_d      = srg_word_t'(1);
          idx_i_d   = StrideA;
          scat_n_d  = '0;
          state_d   = ST_SCAT;
        end
      end
      ST_SCAT: begin
        if (idx_i_q != '0 && scat_n_q < ScatLimit) begin
          ram_we    = 1'b1;
          ram_waddr = idx_i_q;
          ram_wdata = mk_q;
          mk_d      = sub_mod(mj_q, mk_q, m_eff);
          mj_d      = mk_q;
          idx_i_d   = wrap_add(idx_i_q, StrideA);
          scat_n_d  = scat_n_q + 1'b1;
        end else begin
          idx_i_d = '0;
          idx_k_d = MixStartA;
          step_d  = '0;
          state_d = ST_MIX;
        end
      end
      ST_MIX: begin
        if (eval_q) begin
          ram_we    = 1'b1;
          ram_waddr = wa_q;
          ram_wdata = sub_mod(op_a, op_b, m_eff);
        end
        if (step_q != MixSteps) begin
          ram_re  = 1'b1;
          raddr_a = wrap_inc(idx_i_q);
          raddr_b = wrap_inc(idx_k_q);
          idx_i_d = raddr_a;
          idx_k_d = raddr_b;
          wa_d    = raddr_a;
          eval_d  = 1'b1;
          step_d  = step_q + 1'b1;
        end else if (!eval_q) begin
          pos_d   = '0;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    fwd_a_d    = fwd_a_q;
    fwd_b_d    = fwd_b_q;
    fwd_data_d = fwd_data_q;
    if (ram_re) begin
      fwd_a_d    = ram_we && (ram_waddr == raddr_a);
      fwd_b_d    = ram_we && (ram_waddr == raddr_b);
      fwd_data_d = ram_wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      pos_q         <= '0;
      m_valid_q     <= 1'b0;
      m_data_q      <= '0;
      modulus_q     <= ModulusReset;
      seed_offset_q <= SeedOffsetReset;
      mj_q          <= '0;
      mk_q          <= '0;
      idx_i_q       <= '0;
      idx_k_q       <= '0;
      scat_n_q      <= '0;
      step_q        <= '0;
      eval_q        <= 1'b0;
      wa_q          <= '0;
      fwd_a_q       <= 1'b0;
      fwd_b_q       <= 1'b0;
      fwd_data_q    <= '0;
    end else begin
      state_q       <= state_d;
      pos_q         <= pos_d;
      m_valid_q     <= m_valid_d;
      m_data_q      <= m_data_d;
      modulus_q     <= modulus_d;
      seed_offset_q <= seed_offset_d;
      mj_q          <= mj_d;
      mk_q          <= mk_d;
      idx_i_q       <= idx_i_d;
      idx_k_q       <= idx_k_d;
      scat_n_q      <= scat_n_d;
      step_q        <= step_d;
      eval_q        <= eval_d;
      wa_q          <= wa_d;
      fwd_a_q       <= fwd_a_d;
      fwd_b_q       <= fwd_b_d;
      fwd_data_q    <= fwd_data_d;
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {1'b0, m_data_q};
  assign pready        = 1'b1;

  `SRG_ASSERT_ALWAYS(a_pos_range, clk_i, rst_ni, pos_q <= LastA)
  `SRG_ASSERT_IMP(a_out_from_red, clk_i, rst_ni, $rose(m_axis_tvalid), $past(state_q) == ST_NX_RED)
  `SRG_ASSERT_NXT(a_mix_writes, clk_i, rst_ni, (state_q == ST_MIX) && ram_re, ram_we)
  `SRG_ASSERT_IMP(a_no_accept_busy, clk_i, rst_ni, busy_a || busy_b, !s_axis_tready)

endmodule
